// ===== sv/grms_pkg.sv =====
// ----------------------------------------------------------------------------
// grms_pkg
// Shared types and constants for the gravity-removed windowed rms block.
// ----------------------------------------------------------------------------
package grms_pkg;

   localparam int NUM_AXES  = 3;
   localparam int ACCEL_W   = 16;
   localparam int ALPHA_W   = 16;
   localparam int IVAL_W    = 7;
   localparam int RMS_W     = 21;
   localparam int GEST_W    = 34;

   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd62915;
   localparam logic [IVAL_W-1:0]  IVAL_RESET  = 7'd10;

   localparam logic [1:0] REG_ALPHA = 2'd0;
   localparam logic [1:0] REG_IVAL  = 2'd1;

   typedef logic signed [ACCEL_W-1:0] accel_type;

   typedef struct packed {
      logic             seeded;
      logic [ALPHA_W-1:0] alpha;
   } lane_ctl_type;

endpackage

// ===== sv/gravity_removed_windowed_rms.sv =====
// ----------------------------------------------------------------------------
// gravity_removed_windowed_rms
// Three axis lanes remove gravity, squares are merged into a sliding window
// total, and every emit_interval samples a mean and root are produced.
// ----------------------------------------------------------------------------
// sequence: a sample without result passes the lane and merge states; a result adds 53 divide
//   steps plus 27 root steps, then the output state loads the register that drives rsp_tvalid
// throughput: one sample at a time; ready returns once the previous sample
//   is finished and any result has been taken into the output register
// reset: synchronous active high, clears estimates, fill, total and counters;
//   window memory is not cleared (entries are read only after being written)
module gravity_removed_windowed_rms #(
   parameter int WINDOW_DEPTH        = 100,
   parameter int DEVIATION_FRAC_BITS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // accel_x, accel_y, accel_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // rms_level, samples_in_window, window_full
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import grms_pkg::*;

   localparam int DEV_W = 16 + DEVIATION_FRAC_BITS + 2;
   localparam int SQ_W  = 2*DEV_W;
   localparam int SUM_W = SQ_W + 2;
   localparam int TOT_W = SUM_W + $clog2(WINDOW_DEPTH + 1);
   localparam int AW    = $clog2(WINDOW_DEPTH);
   localparam int FW    = $clog2(WINDOW_DEPTH + 1);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001, ST_LANE = 6'b000010, ST_MERGE = 6'b000100,
      ST_ROOT = 6'b001000, ST_WAIT = 6'b010000, ST_OUT = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [ALPHA_W-1:0] alpha_ff;
   logic [IVAL_W-1:0]  ival_ff;
   logic               seeded_ff;
   logic [2:0]         wait_ff;
   logic [AW-1:0]      pos_ff;
   logic [FW-1:0]      fill_ff;
   logic [IVAL_W-1:0]  ecnt_ff, ecnt_inc;
   logic [TOT_W-1:0]   total_ff, total_in;
   logic [SUM_W-1:0]   sum;
   logic [SQ_W-1:0]    sq [NUM_AXES];
   logic [SUM_W-1:0]   old_sq;
   logic               full;
   logic               root_done;
   logic [TOT_W/2:0]   root;
   logic [31:0]        out_ff;
   logic               out_vld_ff;
   logic               out_load;
   logic               accept, csr_wr;
   lane_ctl_type       lane_ctl;
   accel_type          accel [NUM_AXES];

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign full = (fill_ff == FW'(WINDOW_DEPTH));
   // result moves into the output register once the previous one is gone
   assign out_load = (state_ff == ST_OUT) && !out_vld_ff;

   assign lane_ctl.seeded = seeded_ff;
   assign lane_ctl.alpha  = alpha_ff;

   for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
      logic [ACCEL_W-1:0] a_ff;
      always_ff @(posedge clock) begin
         if (accept) begin
            a_ff <= req_tdata[i*ACCEL_W +: ACCEL_W];
         end
      end
      assign accel[i] = accel_type'(a_ff);
      grms_lane #(.FRAC_BITS(DEVIATION_FRAC_BITS), .SQ_W(SQ_W)) u_lane (
         .clock(clock), .reset(reset), .start(state_ff == ST_LANE && wait_ff == 3'd0),
         .ctl(lane_ctl), .accel(accel[i]), .square(sq[i])
      );
   end

   // merge of the three lane results
   assign sum = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);

   grms_ram #(.WIDTH(SUM_W), .DEPTH(WINDOW_DEPTH)) u_ram (
      .clock(clock), .wr_en(state_ff == ST_MERGE), .wr_addr(pos_ff), .wr_data(sum),
      .rd_addr(pos_ff), .rd_data(old_sq)
   );

   always_comb begin
      total_in = total_ff + TOT_W'(sum);
      if (full) begin
         total_in = total_in - TOT_W'(old_sq);
      end
   end

   assign ecnt_inc = ecnt_ff + 1'b1;

   grms_sqrt #(.TOT_W(TOT_W), .CNT_W(FW)) u_sqrt (
      .clock(clock), .reset(reset), .start(state_ff == ST_ROOT),
      .total(total_ff), .count(fill_ff), .done(root_done), .root(root)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_LANE;
         ST_LANE:  if (wait_ff == 3'd4) state_in = ST_MERGE;
         ST_MERGE: state_in = (ecnt_inc >= ival_ff) ? ST_ROOT : ST_IDLE;
         ST_ROOT:  state_in = ST_WAIT;
         ST_WAIT:  if (root_done) state_in = ST_OUT;
         ST_OUT:   if (!out_vld_ff) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         alpha_ff   <= ALPHA_RESET;
         ival_ff    <= IVAL_RESET;
         seeded_ff  <= 1'b0;
         wait_ff    <= '0;
         pos_ff     <= '0;
         fill_ff    <= '0;
         ecnt_ff    <= '0;
         total_ff   <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr) begin
            unique case (csr_paddr[2:2])
               REG_ALPHA[0:0]: alpha_ff <= csr_pwdata[ALPHA_W-1:0];
               REG_IVAL[0:0]:  ival_ff  <= csr_pwdata[IVAL_W-1:0];
               default: ;
            endcase
         end
         wait_ff <= (state_ff == ST_LANE) ? wait_ff + 3'd1 : 3'd0;
         if (state_ff == ST_MERGE) begin
            seeded_ff <= 1'b1;
            total_ff  <= total_in;
            pos_ff    <= (pos_ff == AW'(WINDOW_DEPTH-1)) ? '0 : pos_ff + 1'b1;
            if (!full) begin
               fill_ff <= fill_ff + 1'b1;
            end
            ecnt_ff <= (ecnt_inc >= ival_ff) ? '0 : ecnt_inc;
         end
         if (out_load) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
      end
      if (out_load) begin
         out_ff <= {3'b0, full, IVAL_W'(fill_ff), RMS_W'(root)};
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2:2] == REG_IVAL[0:0]) ? 32'(ival_ff) : 32'(alpha_ff);
endmodule

// ===== sv/grms_ram.sv =====
// ----------------------------------------------------------------------------
// grms_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module grms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== sv/grms_lane.sv =====
// ----------------------------------------------------------------------------
// grms_lane
// One axis: gravity low-pass update and squared rounded deviation, 3 stages.
// ----------------------------------------------------------------------------
module grms_lane #(
   parameter int FRAC_BITS = 4,
   parameter int SQ_W      = 42
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  grms_pkg::lane_ctl_type  ctl,
   input  grms_pkg::accel_type     accel,
   output logic [SQ_W-1:0]         square
);
   import grms_pkg::*;

   localparam int SHIFT = 16 - FRAC_BITS;
   localparam int DEV_W = GEST_W - SHIFT + 1;

   logic signed [GEST_W-1:0] gest_ff, gest_in;
   logic signed [GEST_W-1:0] xs;
   logic signed [GEST_W+17:0] prod_a_ff, prod_b_ff;
   logic signed [GEST_W+18:0] acc;
   logic signed [GEST_W:0]    err;
   logic signed [DEV_W-1:0]   dev_ff;
   logic [SQ_W-1:0]           square_ff;
   logic [1:0]                stage_ff;
   logic signed [GEST_W+18:0] rnd_acc;
   logic signed [GEST_W:0]    rnd_err;

   assign xs = GEST_W'(accel) <<< 16;

   always_ff @(posedge clock) begin
      // products: a*g and (65536-a)*xs
      prod_a_ff <= $signed({1'b0, ctl.alpha}) * gest_ff;
      prod_b_ff <= $signed(18'(17'h10000 - {1'b0, ctl.alpha})) * xs;
      dev_ff    <= DEV_W'(rnd_err >>> SHIFT);
      square_ff <= SQ_W'(dev_ff * dev_ff);
   end

   assign acc     = (GEST_W+19)'(prod_a_ff) + (GEST_W+19)'(prod_b_ff) + 32768;
   assign rnd_acc = acc >>> 16;
   assign err     = (GEST_W+1)'(xs) - (GEST_W+1)'(gest_in);
   assign rnd_err = err + (GEST_W+1)'(1 <<< (SHIFT-1));

   always_comb begin
      gest_in = gest_ff;
      if (stage_ff == 2'd1) begin
         gest_in = ctl.seeded ? GEST_W'(rnd_acc) : xs;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gest_ff  <= '0;
         stage_ff <= '0;
      end else begin
         gest_ff <= gest_in;
         if (start) begin
            stage_ff <= 2'd1;
         end else if (stage_ff != 2'd0) begin
            stage_ff <= stage_ff + 2'd1;
         end
      end
   end

   assign square = square_ff;
endmodule

// ===== sv/grms_sqrt.sv =====
// ----------------------------------------------------------------------------
// grms_sqrt
// Mean by restoring division, then bit-pair integer square root.
// ----------------------------------------------------------------------------
module grms_sqrt #(
   parameter int TOT_W = 52,
   parameter int CNT_W = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [TOT_W-1:0]   total,
   input  logic [CNT_W-1:0]   count,
   output logic               done,
   output logic [TOT_W/2:0]   root
);
   localparam int RW = TOT_W/2 + 1;
   localparam int SW = 2*RW;
   localparam int IW = $clog2(TOT_W + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001, ST_DIV = 3'b010, ST_ROOT = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [TOT_W-1:0] quo_ff, quo_in;
   logic [CNT_W:0]   rem_ff, rem_in;
   logic [CNT_W-1:0] den_ff, den_in;
   logic [IW-1:0]    cnt_ff, cnt_in;
   logic [SW-1:0]    val_ff, val_in;
   logic [RW:0]      rt_ff, rt_in;
   logic [RW+1:0]    sr_ff, sr_in;
   logic [CNT_W:0]   rem_sh;
   logic [RW+1:0]    sr_sh, trial;
   logic             done_ff, done_in;

   always_comb begin
      state_in = state_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      cnt_in   = cnt_ff;
      val_in   = val_ff;
      rt_in    = rt_ff;
      sr_in    = sr_ff;
      done_in  = 1'b0;
      rem_sh   = {rem_ff[CNT_W-1:0], quo_ff[TOT_W-1]};
      sr_sh    = {sr_ff[RW-1:0], val_ff[SW-1:SW-2]};
      trial    = {rt_ff[RW-1:0], 2'b01};
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               quo_in   = total;
               den_in   = count;
               rem_in   = '0;
               cnt_in   = IW'(TOT_W);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            quo_in = {quo_ff[TOT_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in    = rem_sh - {1'b0, den_ff};
               quo_in[0] = 1'b1;
            end else begin
               rem_in = rem_sh;
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == IW'(1)) begin
               val_in   = SW'(quo_in);
               rt_in    = '0;
               sr_in    = '0;
               cnt_in   = IW'(RW);
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            val_in = {val_ff[SW-3:0], 2'b00};
            if (sr_sh >= trial) begin
               sr_in = sr_sh - trial;
               rt_in = {rt_ff[RW-1:0], 1'b1};
            end else begin
               sr_in = sr_sh;
               rt_in = {rt_ff[RW-1:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == IW'(1)) begin
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      val_ff <= val_in;
      rt_ff  <= rt_in;
      sr_ff  <= sr_in;
   end

   assign done = done_ff;
   assign root = rt_ff[RW-1:0];
endmodule

// ===== sv/grms_checker.sv =====
// ----------------------------------------------------------------------------
// grms_checker
// Port-level checks of the response stream and handshake.
// ----------------------------------------------------------------------------
module grms_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped while stalled");
   a_fill_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[27:21] != 7'd0)
      else $error("result with empty window");
   a_one_sample_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("sample taken while another is in progress");
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result after reset");
endmodule

bind gravity_removed_windowed_rms grms_checker u_grms_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
